// File: rtl/shuffled_playlist_sequencer_macros.svh
// Assertion macros for the shuffled playlist sequencer.
`ifndef SHUFFLED_PLAYLIST_SEQUENCER_MACROS_SVH
`define SHUFFLED_PLAYLIST_SEQUENCER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shuffled playlist sequencer check failed");

// Consequent must hold in the cycle after the antecedent.
`define SPS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shuffled playlist sequencer check failed");

`endif

// File: rtl/sps_pkg.sv
// Shared types and constants of the shuffled playlist sequencer.
`timescale 1ns / 1ps
package sps_pkg;

  localparam int POS_W     = 7;
  localparam int SND_W     = 7;
  localparam int OUT_POS_W = 6;
  localparam int RND_W     = 16;
  localparam int CNT_W     = $clog2(RND_W);
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 7;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_SOUNDS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHUFFLE    = 2'd1;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic rd;
    logic rd_j;
    logic cap_a;
    logic cap_b;
    logic wr;
    logic wr_i;
    logic emit;
  } sps_cmd_t;

  typedef struct packed {
    logic n_zero;
    logic shuffle;
    logic div_last;
  } sps_stat_t;

endpackage

// File: rtl/sps_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sps_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/sps_ctrl.sv
// Controller state machine of the shuffled playlist sequencer.
`timescale 1ns / 1ps
module sps_ctrl
  import sps_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  sps_stat_t stat,
  output sps_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_RDI  = 4'd2;
  localparam logic [3:0] S_CAPI = 4'd3;
  localparam logic [3:0] S_RDJ  = 4'd4;
  localparam logic [3:0] S_CAPJ = 4'd5;
  localparam logic [3:0] S_WRJ  = 4'd6;
  localparam logic [3:0] S_WRI  = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (stat.n_zero) begin
            state_next = S_EMIT;
          end else if (stat.shuffle) begin
            state_next = S_DIV;
          end else begin
            state_next = S_RDI;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = S_RDI;
        end
      end
      S_RDI: begin
        cmd.rd     = 1'b1;
        state_next = stat.shuffle ? S_RDJ : S_CAPI;
      end
      S_CAPI: begin
        cmd.cap_b  = 1'b1;
        state_next = S_EMIT;
      end
      S_RDJ: begin
        cmd.rd     = 1'b1;
        cmd.rd_j   = 1'b1;
        cmd.cap_a  = 1'b1;
        state_next = S_CAPJ;
      end
      S_CAPJ: begin
        cmd.cap_b  = 1'b1;
        state_next = S_WRJ;
      end
      S_WRJ: begin
        cmd.wr     = 1'b1;
        state_next = S_WRI;
      end
      S_WRI: begin
        cmd.wr     = 1'b1;
        cmd.wr_i   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: rtl/sps_datapath.sv
// Datapath of the shuffled playlist sequencer: registers, divider and order store.
`timescale 1ns / 1ps
module sps_datapath
  import sps_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [RND_W-1:0]     random_value,
  input  sps_cmd_t             cmd,
  output sps_stat_t            stat,
  output logic                 done,
  output logic [SND_W-1:0]     sound_number,
  output logic [OUT_POS_W-1:0] position,
  output logic                 wrapped,
  output logic                 empty_res
);

  localparam int AW = $clog2(MAX_ENTRIES);

  logic [POS_W-1:0]       num_sounds;
  logic                   shuffle_enable;
  logic [POS_W-1:0]       next_position;
  logic [MAX_ENTRIES-1:0] written_bits;

  logic [POS_W-1:0] pos_i;
  logic [POS_W-1:0] rd_pos;
  logic             wrap_q;
  logic             empty_q;
  logic [RND_W-1:0] dividend;
  logic [POS_W-1:0] rem;
  logic [CNT_W-1:0] div_cnt;
  logic [SND_W-1:0] val_a;
  logic [SND_W-1:0] val_b;

  logic             n_zero;
  logic             need_wrap;
  logic [POS_W-1:0] pos_start;
  logic [POS_W-1:0] divisor;
  logic [POS_W:0]   rem_sh;
  logic [POS_W-1:0] rem_next;
  logic [POS_W-1:0] pos_j;
  logic [POS_W-1:0] rd_sel;
  logic [SND_W-1:0] ram_q;
  logic [SND_W-1:0] entry_val;
  logic [POS_W-1:0] wr_pos;
  logic [SND_W-1:0] wr_val;

  assign n_zero    = (num_sounds == '0);
  assign need_wrap = (next_position >= num_sounds);
  assign pos_start = (n_zero || need_wrap) ? '0 : next_position;

  assign divisor  = num_sounds - pos_i;
  assign rem_sh   = {rem, dividend[RND_W-1]};
  assign rem_next = (rem_sh >= {1'b0, divisor}) ? POS_W'(rem_sh - {1'b0, divisor})
                                                : rem_sh[POS_W-1:0];
  assign pos_j    = pos_i + rem;

  assign rd_sel    = cmd.rd_j ? pos_j : pos_i;
  assign entry_val = written_bits[AW'(rd_pos)] ? ram_q : SND_W'(rd_pos + POS_W'(1));
  assign wr_pos    = cmd.wr_i ? pos_i : pos_j;
  assign wr_val    = cmd.wr_i ? val_b : val_a;

  assign stat.n_zero   = n_zero;
  assign stat.shuffle  = shuffle_enable;
  assign stat.div_last = (div_cnt == {CNT_W{1'b1}});

  sps_ram #(
    .WIDTH(SND_W),
    .DEPTH(MAX_ENTRIES)
  ) u_order_store (
    .clk  (clk),
    .we   (cmd.wr),
    .waddr(AW'(wr_pos)),
    .wdata(wr_val),
    .raddr(AW'(rd_sel)),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      num_sounds     <= '0;
      shuffle_enable <= 1'b0;
      next_position  <= '0;
      written_bits   <= '0;
      done           <= 1'b0;
    end else begin
      done <= cmd.emit;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_NUM_SOUNDS: begin
            num_sounds <= ({1'b0, cfg_data} > 8'(MAX_ENTRIES)) ? '0 : cfg_data;
          end
          REG_SHUFFLE: begin
            shuffle_enable <= cfg_data[0];
          end
          default: begin
          end
        endcase
      end
      priority if (cmd.accept) begin
        next_position <= n_zero ? '0 : pos_start + POS_W'(1);
        if (n_zero || need_wrap) begin
          written_bits <= '0;
        end
      end else if (cmd.wr) begin
        written_bits[AW'(wr_pos)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pos_i    <= pos_start;
      wrap_q   <= !n_zero && need_wrap;
      empty_q  <= n_zero;
      dividend <= random_value;
      rem      <= '0;
      div_cnt  <= '0;
    end
    if (cmd.div_step) begin
      rem      <= rem_next;
      dividend <= {dividend[RND_W-2:0], 1'b0};
      div_cnt  <= div_cnt + CNT_W'(1);
    end
    if (cmd.rd) begin
      rd_pos <= rd_sel;
    end
    if (cmd.cap_a) begin
      val_a <= entry_val;
    end
    if (cmd.cap_b) begin
      val_b <= entry_val;
    end
    if (cmd.emit) begin
      sound_number <= empty_q ? '0 : val_b;
      position     <= empty_q ? '0 : pos_i[OUT_POS_W-1:0];
      wrapped      <= wrap_q;
      empty_res    <= empty_q;
    end
  end

endmodule

// File: rtl/shuffled_playlist_sequencer.sv
// Top level of the shuffled playlist sequencer.
`timescale 1ns / 1ps
`include "shuffled_playlist_sequencer_macros.svh"
// A request is taken when start is high and busy is low, and its result is
// shown for one cycle with done high; the receiver cannot stall, so results
// must be taken as they appear. Busy stays high while the controller passes
// through S_EMIT alone with an empty playlist, S_RDI, S_CAPI and S_EMIT with
// shuffle off, or S_DIV, S_RDI, S_RDJ, S_CAPJ, S_WRJ, S_WRI and S_EMIT with
// shuffle on; done is registered from S_EMIT. The shuffle path is longest: a
// 16-step bit-serial remainder unit and an order store with one read and one
// write port (two reads, two writes in turn). A new request may be issued in
// the cycle that done is high. Configuration writes are always ready and must
// be issued only while busy is low and no result is pending.
module shuffled_playlist_sequencer
  import sps_pkg::*;
#(
  parameter int MAX_ENTRIES = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [RND_W-1:0]     random_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 done,
  output logic [SND_W-1:0]     sound_number,
  output logic [OUT_POS_W-1:0] position,
  output logic                 wrapped,
  output logic                 empty_res
);

  sps_cmd_t  cmd;
  sps_stat_t stat;

  assign cfg_ready = 1'b1;

  sps_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  sps_datapath #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .random_value(random_value),
    .cmd         (cmd),
    .stat        (stat),
    .done        (done),
    .sound_number(sound_number),
    .position    (position),
    .wrapped     (wrapped),
    .empty_res   (empty_res)
  );

  `SPS_ASSERT_IMPL(a_done_when_idle, clk, rst, done, !busy)
  `SPS_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy || done)
  `SPS_ASSERT_IMPL(a_empty_zero, clk, rst, done && empty_res, sound_number == '0 && !wrapped)
  `SPS_ASSERT_IMPL(a_sound_nonzero, clk, rst, done && !empty_res, sound_number != '0)

endmodule
